@@ src/via_pkg.sv @@
// Shared types and register map for the versatile interface adapter.
package via_pkg;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpTick  = 2'd2,
    OpCa1   = 2'd3
  } op_e;

  localparam logic [3:0] RegOrb   = 4'd0;
  localparam logic [3:0] RegOra   = 4'd1;
  localparam logic [3:0] RegDdrb  = 4'd2;
  localparam logic [3:0] RegDdra  = 4'd3;
  localparam logic [3:0] RegT1cl  = 4'd4;
  localparam logic [3:0] RegT1ch  = 4'd5;
  localparam logic [3:0] RegT1ll  = 4'd6;
  localparam logic [3:0] RegT1lh  = 4'd7;
  localparam logic [3:0] RegT2cl  = 4'd8;
  localparam logic [3:0] RegT2ch  = 4'd9;
  localparam logic [3:0] RegAcr   = 4'd11;
  localparam logic [3:0] RegPcr   = 4'd12;
  localparam logic [3:0] RegIfr   = 4'd13;
  localparam logic [3:0] RegIer   = 4'd14;
  localparam logic [3:0] RegOraNh = 4'd15;

  typedef struct packed {
    op_e        opcode;
    logic [3:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } rsp_t;

endpackage

@@ src/via_core.sv @@
// Register file, timers and interrupt logic of the interface adapter.
module via_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  via_pkg::req_t   req_i,
  output via_pkg::rsp_t   rsp_o
);

  localparam int unsigned FlagCa2 = 0;
  localparam int unsigned FlagCa1 = 1;
  localparam int unsigned FlagT2  = 5;
  localparam int unsigned FlagT1  = 6;

  logic [7:0]  pbo_q, pbo_d;
  logic        pbi7_q, pbi7_d;
  logic [7:0]  ddra_q, ddra_d;
  logic [7:0]  ddrb_q, ddrb_d;
  logic [15:0] t1_latch_q, t1_latch_d;
  logic [15:0] t2_latch_q, t2_latch_d;
  logic [18:0] t1_cnt_q, t1_cnt_d;
  logic [18:0] t2_cnt_q, t2_cnt_d;
  logic        t1_fired_q, t1_fired_d;
  logic [7:0]  acr_q, acr_d;
  logic [7:0]  pcr_q, pcr_d;
  logic [6:0]  ifr_q, ifr_d;
  logic [6:0]  ier_q, ier_d;
  logic [7:0]  rdata;
  logic [18:0] t1_sub, t2_sub;
  logic [15:0] new_latch;
  logic        irq_now;

  function automatic logic [7:0] count_lo(logic [18:0] cnt, logic [15:0] latch,
                                          logic upper);
    logic [18:0] lim;
    logic [19:0] adj;
    lim = {2'b00, latch, 1'b0};
    adj = {cnt[18], cnt} + (upper ? {11'd0, {9{cnt[18]}}} : {19'd0, cnt[18]});
    if ($signed(cnt) > $signed(lim)) begin
      return 8'hFF;
    end
    return upper ? adj[16:9] : adj[8:1];
  endfunction

  assign irq_now = |(ifr_q & ier_q);
  assign t1_sub  = t1_cnt_q - {11'd0, req_i.tick_cycles};
  assign t2_sub  = t2_cnt_q - {11'd0, req_i.tick_cycles};

  always_comb begin
    pbo_d      = pbo_q;
    pbi7_d     = pbi7_q;
    ddra_d     = ddra_q;
    ddrb_d     = ddrb_q;
    t1_latch_d = t1_latch_q;
    t2_latch_d = t2_latch_q;
    t1_cnt_d   = t1_cnt_q;
    t2_cnt_d   = t2_cnt_q;
    t1_fired_d = t1_fired_q;
    acr_d      = acr_q;
    pcr_d      = pcr_q;
    ifr_d      = ifr_q;
    ier_d      = ier_q;
    rdata      = 8'hFF;
    new_latch  = {req_i.write_data, t1_latch_q[7:0]};
    case (req_i.opcode)
      via_pkg::OpWrite: begin
        case (req_i.reg_address)
          via_pkg::RegOrb: begin
            pbo_d = req_i.write_data;
            if (!pcr_q[1]) begin
              ifr_d[FlagCa2] = 1'b0;
            end
          end
          via_pkg::RegOra: begin
            ifr_d[FlagCa1] = 1'b0;
            ifr_d[FlagCa2] = 1'b0;
          end
          via_pkg::RegDdrb: ddrb_d = req_i.write_data;
          via_pkg::RegDdra: ddra_d = req_i.write_data;
          via_pkg::RegT1cl, via_pkg::RegT1ll: t1_latch_d[7:0] = req_i.write_data;
          via_pkg::RegT1ch: begin
            t1_latch_d    = new_latch;
            t1_cnt_d      = {2'b00, new_latch, 1'b0};
            ifr_d[FlagT1] = 1'b0;
            t1_fired_d    = 1'b0;
            if (acr_q[7]) begin
              pbo_d[7] = 1'b0;
              pbi7_d   = 1'b0;
            end
          end
          via_pkg::RegT1lh: t1_latch_d[15:8] = req_i.write_data;
          via_pkg::RegT2cl: t2_latch_d[7:0] = req_i.write_data;
          via_pkg::RegT2ch: begin
            t2_latch_d    = {req_i.write_data, t2_latch_q[7:0]};
            t2_cnt_d      = {2'b00, req_i.write_data, t2_latch_q[7:0], 1'b0};
            ifr_d[FlagT2] = 1'b0;
          end
          via_pkg::RegAcr: acr_d = req_i.write_data;
          via_pkg::RegPcr: pcr_d = req_i.write_data;
          via_pkg::RegIfr: ifr_d = ifr_q & ~req_i.write_data[6:0];
          via_pkg::RegIer: begin
            if (req_i.write_data[7]) begin
              ier_d = ier_q | req_i.write_data[6:0];
            end else begin
              ier_d = ier_q & ~req_i.write_data[6:0];
            end
          end
          default: ;
        endcase
      end
      via_pkg::OpRead: begin
        case (req_i.reg_address)
          via_pkg::RegOrb: rdata = (pbo_q & ddrb_q) | ({pbi7_q, 7'd0} & ~ddrb_q);
          via_pkg::RegOra: begin
            ifr_d[FlagCa1] = 1'b0;
            ifr_d[FlagCa2] = 1'b0;
          end
          via_pkg::RegDdrb: rdata = ddrb_q;
          via_pkg::RegDdra: rdata = ddra_q;
          via_pkg::RegT1cl: begin
            rdata         = count_lo(t1_cnt_q, t1_latch_q, 1'b0);
            ifr_d[FlagT1] = 1'b0;
          end
          via_pkg::RegT1ch: rdata = count_lo(t1_cnt_q, t1_latch_q, 1'b1);
          via_pkg::RegT1ll: rdata = t1_latch_q[7:0];
          via_pkg::RegT1lh: rdata = t1_latch_q[15:8];
          via_pkg::RegT2cl: begin
            rdata         = count_lo(t2_cnt_q, t2_latch_q, 1'b0);
            ifr_d[FlagT2] = 1'b0;
          end
          via_pkg::RegT2ch: rdata = count_lo(t2_cnt_q, t2_latch_q, 1'b1);
          via_pkg::RegIfr: rdata = {irq_now, ifr_q};
          via_pkg::RegIer: rdata = {1'b1, ier_q};
          default: ;
        endcase
      end
      via_pkg::OpTick: begin
        t1_cnt_d = t1_sub;
        t2_cnt_d = t2_sub;
        if (t1_sub[18]) begin
          t1_cnt_d = t1_sub + {2'b00, t1_latch_q, 1'b0} + 19'd4;
          if (!t1_fired_q || acr_q[6]) begin
            ifr_d[FlagT1] = 1'b1;
            if (acr_q[7]) begin
              pbo_d[7] = ~pbo_q[7];
              pbi7_d   = ~pbi7_q;
            end
          end
          t1_fired_d = 1'b1;
        end
        if (t2_sub[18]) begin
          t2_cnt_d      = t2_sub + {2'b00, t2_latch_q, 1'b0} + 19'd4;
          ifr_d[FlagT2] = 1'b1;
        end
      end
      via_pkg::OpCa1: ifr_d[FlagCa1] = 1'b1;
      default: ;
    endcase
  end

  assign rsp_o.read_data = rdata;
  assign rsp_o.irq       = |(ifr_d & ier_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbo_q      <= '0;
      pbi7_q     <= 1'b0;
      ddra_q     <= '0;
      ddrb_q     <= '0;
      t1_latch_q <= '0;
      t2_latch_q <= '0;
      t1_cnt_q   <= '0;
      t2_cnt_q   <= '0;
      t1_fired_q <= 1'b0;
      acr_q      <= '0;
      pcr_q      <= '0;
      ifr_q      <= '0;
      ier_q      <= '0;
    end else if (fire_i) begin
      pbo_q      <= pbo_d;
      pbi7_q     <= pbi7_d;
      ddra_q     <= ddra_d;
      ddrb_q     <= ddrb_d;
      t1_latch_q <= t1_latch_d;
      t2_latch_q <= t2_latch_d;
      t1_cnt_q   <= t1_cnt_d;
      t2_cnt_q   <= t2_cnt_d;
      t1_fired_q <= t1_fired_d;
      acr_q      <= acr_d;
      pcr_q      <= pcr_d;
      ifr_q      <= ifr_d;
      ier_q      <= ier_d;
    end
  end

endmodule

@@ src/versatile_interface_adapter.sv @@
// Top level of the versatile interface adapter: input and result registers around the core.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one word per cycle while
//   in_ready_o is high: a register write, a register read, a timer tick
//   that advances both timers by tick_cycles_i, or a CA1 edge event, chosen by opcode_i.
//   Every word yields exactly one result word on the output channel
//   (out_valid_o / out_ready_i): read_data_o holds the read byte (255 for
//   anything other than a read) and irq_o the interrupt line after the word.
//   A word accepted into the input register passes the core logic into the result
//   register. Throughput: one word per cycle while the receiver keeps up, set by
//   the single register stage in front of the core logic and the result register.
//   Reset clears all ports, timers, latches, control and interrupt registers,
//   and empties both register stages.
//   When the receiver stalls, the result register holds its word, the input
//   register holds the next one, and in_ready_o drops once both are full.
module versatile_interface_adapter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [3:0] reg_address_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] tick_cycles_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_o
);

  logic            in_valid_q;
  via_pkg::req_t   in_req_q;
  logic            out_valid_q;
  via_pkg::rsp_t   out_rsp_q;
  via_pkg::rsp_t   core_rsp;
  logic            advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  via_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_req_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q.opcode      <= via_pkg::op_e'(opcode_i);
      in_req_q.reg_address <= reg_address_i;
      in_req_q.write_data  <= write_data_i;
      in_req_q.tick_cycles <= tick_cycles_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= core_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rsp_q.read_data;
  assign irq_o       = out_rsp_q.irq;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for versatile_interface_adapter against a register predictor.
module tb_top;

  localparam logic [3:0] RegSpare = 4'd10;
  localparam int FlagCa1 = 1;
  localparam int FlagT2 = 5;
  localparam int FlagT1 = 6;
  localparam int FlagIrq = 7;
  localparam int AcrFreeRun = 6;
  localparam int AcrPb7 = 7;
  localparam int PcrCa2Mode = 1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  via_pkg::op_e word_op = via_pkg::OpWrite;
  logic [3:0]   word_addr = '0;
  logic [7:0]   word_data = '0;
  logic [7:0]   word_cycles = 8'd1;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [7:0]   read_data;
  logic         irq;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int words_sent = 0;
  int reads_sent = 0;
  int ticks_sent = 0;
  int ca1_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  via_pkg::rsp_t expected_q[$];

  logic [7:0]  pa_out = '0, pb_out = '0, pb_pins = '0, pa_dir = '0, pb_dir = '0;
  logic [15:0] t1_latch = '0, t2_latch = '0;
  logic [18:0] t1_cnt = '0, t2_cnt = '0;
  logic        t1_done = 1'b0;
  logic [7:0]  acr = '0, pcr = '0, ifr = '0, ier = '0;

  versatile_interface_adapter dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (word_op),
    .reg_address_i(word_addr),
    .write_data_i (word_data),
    .tick_cycles_i(word_cycles),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data),
    .irq_o        (irq)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int cnt_int(logic [18:0] c);
    return int'($signed(c));
  endfunction

  function automatic void refresh_line();
    ifr[FlagIrq] = |(ifr[6:0] & ier[6:0]);
  endfunction

  function automatic logic [18:0] reload_cnt(logic [18:0] c, logic [15:0] latch);
    int v;
    v = 2 * int'(latch) + cnt_int(c) + 4;
    return v[18:0];
  endfunction

  function automatic logic [7:0] cnt_byte(logic [18:0] c, logic [15:0] latch, int div);
    int v;
    int q;
    v = cnt_int(c);
    if (v > 2 * int'(latch)) return 8'hFF;
    q = v / div;
    return q[7:0];
  endfunction

  function automatic void write_reg(logic [3:0] addr, logic [7:0] d);
    case (addr)
      via_pkg::RegOrb: begin
        pb_out = d;
        if (ifr[0] && !pcr[PcrCa2Mode]) begin
          ifr[0] = 1'b0;
          refresh_line();
        end
      end
      via_pkg::RegOra: begin
        pa_out = d;
        ifr[1:0] = 2'b00;
        refresh_line();
      end
      via_pkg::RegDdrb: pb_dir = d;
      via_pkg::RegDdra: pa_dir = d;
      via_pkg::RegT1cl, via_pkg::RegT1ll: t1_latch[7:0] = d;
      via_pkg::RegT1ch: begin
        t1_latch[15:8] = d;
        t1_cnt = {2'b00, t1_latch, 1'b0};
        ifr[FlagT1] = 1'b0;
        t1_done = 1'b0;
        if (acr[AcrPb7]) begin
          pb_out[7] = 1'b0;
          pb_pins[7] = 1'b0;
        end
        refresh_line();
      end
      via_pkg::RegT1lh: t1_latch[15:8] = d;
      via_pkg::RegT2cl: t2_latch[7:0] = d;
      via_pkg::RegT2ch: begin
        t2_latch[15:8] = d;
        t2_cnt = {2'b00, t2_latch, 1'b0};
        ifr[FlagT2] = 1'b0;
        refresh_line();
      end
      via_pkg::RegAcr: acr = d;
      via_pkg::RegPcr: pcr = d;
      via_pkg::RegIfr: begin
        ifr = ifr & ~d;
        refresh_line();
      end
      via_pkg::RegIer: begin
        if (d[7]) ier = ier | d;
        else ier = ier & ~d;
        ier[7] = 1'b0;
        refresh_line();
      end
      via_pkg::RegOraNh: pa_out = d;
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] read_reg(logic [3:0] addr);
    logic [7:0] r;
    r = 8'hFF;
    case (addr)
      via_pkg::RegOrb: r = (pb_out & pb_dir) | (pb_pins & ~pb_dir);
      via_pkg::RegOra: begin
        ifr[1:0] = 2'b00;
        refresh_line();
      end
      via_pkg::RegDdrb: r = pb_dir;
      via_pkg::RegDdra: r = pa_dir;
      via_pkg::RegT1cl: begin
        r = cnt_byte(t1_cnt, t1_latch, 2);
        ifr[FlagT1] = 1'b0;
        refresh_line();
      end
      via_pkg::RegT1ch: r = cnt_byte(t1_cnt, t1_latch, 512);
      via_pkg::RegT1ll: r = t1_latch[7:0];
      via_pkg::RegT1lh: r = t1_latch[15:8];
      via_pkg::RegT2cl: begin
        r = cnt_byte(t2_cnt, t2_latch, 2);
        ifr[FlagT2] = 1'b0;
        refresh_line();
      end
      via_pkg::RegT2ch: r = cnt_byte(t2_cnt, t2_latch, 512);
      via_pkg::RegIfr: begin
        refresh_line();
        r = ifr;
      end
      via_pkg::RegIer: r = ier | 8'h80;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void advance_timers(logic [7:0] cyc);
    int v;
    v = cnt_int(t1_cnt) - int'(cyc);
    t1_cnt = v[18:0];
    v = cnt_int(t2_cnt) - int'(cyc);
    t2_cnt = v[18:0];
    if (cnt_int(t1_cnt) < 0) begin
      t1_cnt = reload_cnt(t1_cnt, t1_latch);
      if (!t1_done || acr[AcrFreeRun]) begin
        ifr[FlagT1] = 1'b1;
        refresh_line();
        if (acr[AcrPb7]) begin
          pb_out[7] = ~pb_out[7];
          pb_pins[7] = ~pb_pins[7];
        end
      end
      t1_done = 1'b1;
    end
    if (cnt_int(t2_cnt) < 0) begin
      t2_cnt = reload_cnt(t2_cnt, t2_latch);
      if (!ifr[FlagT2]) begin
        ifr[FlagT2] = 1'b1;
        refresh_line();
      end
    end
  endfunction

  function automatic via_pkg::rsp_t predict_word(via_pkg::op_e op, logic [3:0] addr,
                                                 logic [7:0] d, logic [7:0] cyc);
    via_pkg::rsp_t res;
    res.read_data = 8'hFF;
    case (op)
      via_pkg::OpWrite: write_reg(addr, d);
      via_pkg::OpRead:  res.read_data = read_reg(addr);
      via_pkg::OpTick:  advance_timers(cyc);
      via_pkg::OpCa1: begin
        ifr[FlagCa1] = 1'b1;
        refresh_line();
      end
      default: ;
    endcase
    res.irq = ifr[FlagIrq];
    return res;
  endfunction

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    via_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: read_data %02h irq %0b", read_data, irq);
      end else begin
        want = expected_q.pop_front();
        if (want.read_data !== read_data || want.irq !== irq) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected read_data %02h irq %0b, got %02h irq %0b",
                     results_seen, want.read_data, want.irq, read_data, irq);
        end
      end
    end
  end

  task automatic send_word(via_pkg::op_e op, logic [3:0] addr, logic [7:0] d,
                           logic [7:0] cyc);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    word_op     <= op;
    word_addr   <= addr;
    word_data   <= d;
    word_cycles <= cyc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_word(op, addr, d, cyc));
    words_sent++;
    case (op)
      via_pkg::OpRead: reads_sent++;
      via_pkg::OpTick: ticks_sent++;
      via_pkg::OpCa1:  ca1_sent++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_random_word();
    via_pkg::op_e op;
    logic [3:0]   addr;
    logic [7:0]   d;
    logic [7:0]   cyc;
    int           pick;
    pick = int'($urandom_range(99));
    if (pick < 35) op = via_pkg::OpWrite;
    else if (pick < 70) op = via_pkg::OpRead;
    else if (pick < 90) op = via_pkg::OpTick;
    else op = via_pkg::OpCa1;
    addr = 4'($urandom_range(15));
    d = 8'($urandom_range(255));
    // keep timer periods short so the timers expire often
    if (op == via_pkg::OpWrite && (addr == via_pkg::RegT1ch || addr == via_pkg::RegT1lh ||
        addr == via_pkg::RegT2ch) && $urandom_range(9) < 7)
      d = 8'($urandom_range(3));
    if ($urandom_range(1) == 1) cyc = 8'($urandom_range(20, 1));
    else cyc = 8'($urandom_range(255, 1));
    send_word(op, addr, d, cyc);
  endtask

  task automatic test_directed();
    send_word(via_pkg::OpRead,  via_pkg::RegIer,   8'h00, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegIfr,   8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegDdrb,  8'h0F, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegOrb,   8'hA5, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegOrb,   8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegDdra,  8'hFF, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegDdra,  8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegIer,   8'hFF, 8'd1);
    send_word(via_pkg::OpCa1,   via_pkg::RegOrb,   8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegOraNh, 8'h00, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegIfr,   8'h00, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegOra,   8'h00, 8'd1);
    send_word(via_pkg::OpWrite, RegSpare,          8'h55, 8'd1);
    send_word(via_pkg::OpRead,  RegSpare,          8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegAcr,   8'hC0, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegT1ll,  8'h04, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegT1ch,  8'h00, 8'd1);
    send_word(via_pkg::OpTick,  via_pkg::RegOrb,   8'h00, 8'd255);
    send_word(via_pkg::OpRead,  via_pkg::RegOrb,   8'h00, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegT1cl,  8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegT2cl,  8'hFF, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegT2ch,  8'hFF, 8'd1);
    send_word(via_pkg::OpTick,  via_pkg::RegOrb,   8'h00, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegT2ch,  8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegT1lh,  8'hFF, 8'd1);
    send_word(via_pkg::OpRead,  via_pkg::RegT1ch,  8'h00, 8'd1);
    send_word(via_pkg::OpWrite, via_pkg::RegIer,   8'h7F, 8'd1);
  endtask

  task automatic test_random_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_random_word();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 200;
    repeat (40) send_random_word();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(700, 19, 47);
    test_random_phase(700, 47, 19);
    test_random_phase(600, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d words: %0d reads, %0d ticks, %0d CA1 events; %0d results checked",
             words_sent, reads_sent, ticks_sent, ca1_sent, results_seen);
    $display("idle mixes on both sides plus one long output stall; %0d mismatches",
             mismatches);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
